/* rtl/tps_pkg.sv */
// shared types, constants and the log table of the thin-plate spline mapper
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_INT_BITS = 10;
  localparam int FRAC_BITS      = 4;
  localparam int POS_W          = 14;
  localparam int USED_W         = (COORD_INT_BITS + FRAC_BITS < POS_W) ?
                                  COORD_INT_BITS + FRAC_BITS : POS_W;
  localparam logic [POS_W-1:0] POS_MASK = POS_W'((64'd1 << USED_W) - 64'd1);
  localparam int COEF_W         = 32;
  localparam int OUT_W          = 40;
  localparam int AFFINE_ROWS    = 4;
  localparam int LN2_Q16        = 45426;

  // item modes
  localparam logic [1:0] MODE_COEF = 2'd0;
  localparam logic [1:0] MODE_PT   = 2'd1;
  localparam logic [1:0] MODE_MAP  = 2'd2;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP, OP_LDCOEF, OP_LDPT, OP_START,
    OP_ARD, OP_AMUL, OP_AACC, OP_ASAT,
    OP_PRD, OP_DIST, OP_SUM, OP_LZ, OP_LN1, OP_LN2, OP_KM,
    OP_T1, OP_T2, OP_ADD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] row;
  } cmd_t;

  // round(65536*ln(1+k/16))
  function automatic logic [15:0] ln_tab(input logic [4:0] k);
    logic [15:0] r;
    case (k)
      5'd0:  r = 16'd0;
      5'd1:  r = 16'd3973;
      5'd2:  r = 16'd7719;
      5'd3:  r = 16'd11262;
      5'd4:  r = 16'd14624;
      5'd5:  r = 16'd17821;
      5'd6:  r = 16'd20870;
      5'd7:  r = 16'd23783;
      5'd8:  r = 16'd26573;
      5'd9:  r = 16'd29248;
      5'd10: r = 16'd31818;
      5'd11: r = 16'd34292;
      5'd12: r = 16'd36675;
      5'd13: r = 16'd38975;
      5'd14: r = 16'd41196;
      5'd15: r = 16'd43345;
      5'd16: r = 16'd45426;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/thin_plate_spline_warp.sv */
// top level of the thin-plate spline coordinate mapper
`timescale 1ns / 1ps
`default_nettype none
// Loads (mode 0 coefficient row, mode 1 control point) complete on acceptance and busy stays
// low. A map item (mode 2) keeps busy high through the affine work (read, multiply and
// accumulate for each affine row, then saturate), the per-point work for each of the
// N = min(active_points, MAX_POINTS) active points and the result strobe, and no new
// item is accepted until busy falls again. The per-point work runs on the single shared chain
// of distance, log, kernel multiply and accumulate stages that every point walks
// through in turn. done_o marks the result for exactly one cycle and the receiver
// cannot hold it off; the outputs keep their values until the next map.
module thin_plate_spline_warp #(
  parameter int MAX_POINTS = tps_pkg::MAX_POINTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode_i,
  input  wire logic [6:0]         index_i,
  input  wire logic signed [31:0] coef_x_i,
  input  wire logic signed [31:0] coef_y_i,
  input  wire logic signed [31:0] coef_z_i,
  input  wire logic [13:0]        pos_x_i,
  input  wire logic [13:0]        pos_y_i,
  input  wire logic [13:0]        pos_z_i,
  input  wire logic               cfg_we_i,
  input  wire logic [6:0]         cfg_wdata_i,
  output logic                    done_o,
  output logic signed [39:0]      mapped_x_o,
  output logic signed [39:0]      mapped_y_o,
  output logic signed [39:0]      mapped_z_o,
  output logic                    overflow_o
);
  import tps_pkg::*;

  localparam int PIW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  cmd_t           cmd;
  logic [PIW-1:0] pt;

  tps_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .PIW        (PIW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .mode_i      (mode_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .pt_o        (pt),
    .busy        (busy),
    .done_o      (done_o)
  );

  tps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .PIW        (PIW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .pt_i       (pt),
    .index_i    (index_i),
    .coef_x_i   (coef_x_i),
    .coef_y_i   (coef_y_i),
    .coef_z_i   (coef_z_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .mapped_x_o (mapped_x_o),
    .mapped_y_o (mapped_y_o),
    .mapped_z_o (mapped_z_o),
    .overflow_o (overflow_o)
  );

  // a result only comes out of a running map
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe while idle");

  // an accepted map keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_MAP) |=> (busy && !done_o))
    else $error("map item did not start");

  // loads and ignored modes finish at once with no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i != MODE_MAP) |=> (!busy && !done_o))
    else $error("load item produced activity");

  // the block returns to idle right after a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy)
    else $error("busy after result");

endmodule
`default_nettype wire

/* rtl/tps_ctrl.sv */
// sequencer for loads and the per-point mapping loop
`timescale 1ns / 1ps
`default_nettype none
module tps_ctrl #(
  parameter int MAX_POINTS = 64,
  parameter int PIW = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic [1:0]      mode_i,
  input  wire logic            cfg_we_i,
  input  wire logic [6:0]      cfg_wdata_i,
  output tps_pkg::cmd_t        cmd_o,
  output logic [PIW-1:0]       pt_o,
  output logic                 busy,
  output logic                 done_o
);
  import tps_pkg::*;

  localparam int PCW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ARD  = 5'd1;
  localparam logic [4:0] S_AMUL = 5'd2;
  localparam logic [4:0] S_AACC = 5'd3;
  localparam logic [4:0] S_ASAT = 5'd4;
  localparam logic [4:0] S_PRD  = 5'd5;
  localparam logic [4:0] S_DIST = 5'd6;
  localparam logic [4:0] S_SUM  = 5'd7;
  localparam logic [4:0] S_LZ   = 5'd8;
  localparam logic [4:0] S_LN1  = 5'd9;
  localparam logic [4:0] S_LN2  = 5'd10;
  localparam logic [4:0] S_KM   = 5'd11;
  localparam logic [4:0] S_T1   = 5'd12;
  localparam logic [4:0] S_T2   = 5'd13;
  localparam logic [4:0] S_ADD  = 5'd14;
  localparam logic [4:0] S_DONE = 5'd15;

  logic [4:0]     state_q, state_d;
  logic [1:0]     row_q, row_d;
  logic [PCW-1:0] pt_q, pt_d;
  logic [6:0]     active_q;
  logic [PCW-1:0] n_pts;
  logic           accept;

  assign accept = start && (state_q == S_IDLE);
  assign n_pts  = (32'(active_q) > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(active_q);

  // active point count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    pt_d    = pt_q;
    case (state_q)
      S_IDLE: begin
        if (accept && mode_i == MODE_MAP) begin
          state_d = S_ARD;
          row_d   = 2'd0;
        end
      end
      S_ARD:  state_d = S_AMUL;
      S_AMUL: state_d = S_AACC;
      S_AACC: begin
        if (row_q == 2'd3) begin
          state_d = S_ASAT;
        end else begin
          row_d   = row_q + 2'd1;
          state_d = S_ARD;
        end
      end
      S_ASAT: begin
        pt_d    = '0;
        state_d = (n_pts == '0) ? S_DONE : S_PRD;
      end
      S_PRD:  state_d = S_DIST;
      S_DIST: state_d = S_SUM;
      S_SUM:  state_d = S_LZ;
      S_LZ:   state_d = S_LN1;
      S_LN1:  state_d = S_LN2;
      S_LN2:  state_d = S_KM;
      S_KM:   state_d = S_T1;
      S_T1:   state_d = S_T2;
      S_T2:   state_d = S_ADD;
      S_ADD: begin
        if (pt_q == n_pts - PCW'(1)) begin
          state_d = S_DONE;
        end else begin
          pt_d    = pt_q + PCW'(1);
          state_d = S_PRD;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      pt_q    <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      pt_q    <= pt_d;
    end
  end

  // command decode
  always_comb begin
    cmd_o.row = row_q;
    case (state_q)
      S_IDLE: begin
        if (accept && mode_i == MODE_COEF) begin
          cmd_o.op = OP_LDCOEF;
        end else if (accept && mode_i == MODE_PT) begin
          cmd_o.op = OP_LDPT;
        end else if (accept && mode_i == MODE_MAP) begin
          cmd_o.op = OP_START;
        end else begin
          cmd_o.op = OP_NOP;
        end
      end
      S_ARD:  cmd_o.op = OP_ARD;
      S_AMUL: cmd_o.op = OP_AMUL;
      S_AACC: cmd_o.op = OP_AACC;
      S_ASAT: cmd_o.op = OP_ASAT;
      S_PRD:  cmd_o.op = OP_PRD;
      S_DIST: cmd_o.op = OP_DIST;
      S_SUM:  cmd_o.op = OP_SUM;
      S_LZ:   cmd_o.op = OP_LZ;
      S_LN1:  cmd_o.op = OP_LN1;
      S_LN2:  cmd_o.op = OP_LN2;
      S_KM:   cmd_o.op = OP_KM;
      S_T1:   cmd_o.op = OP_T1;
      S_T2:   cmd_o.op = OP_T2;
      S_ADD:  cmd_o.op = OP_ADD;
      default: cmd_o.op = OP_NOP;
    endcase
  end

  assign pt_o   = pt_q[PIW-1:0];
  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule
`default_nettype wire

/* rtl/tps_datapath.sv */
// coefficient and point stores, affine lanes, log unit and kernel accumulators
`timescale 1ns / 1ps
`default_nettype none
module tps_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int PIW = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  tps_pkg::cmd_t                      cmd_i,
  input  wire logic [PIW-1:0]                pt_i,
  input  wire logic [6:0]                    index_i,
  input  wire logic signed [31:0]            coef_x_i,
  input  wire logic signed [31:0]            coef_y_i,
  input  wire logic signed [31:0]            coef_z_i,
  input  wire logic [13:0]                   pos_x_i,
  input  wire logic [13:0]                   pos_y_i,
  input  wire logic [13:0]                   pos_z_i,
  output logic signed [39:0]                 mapped_x_o,
  output logic signed [39:0]                 mapped_y_o,
  output logic signed [39:0]                 mapped_z_o,
  output logic                               overflow_o
);
  import tps_pkg::*;

  localparam int ROWS = MAX_POINTS + AFFINE_ROWS;
  localparam int RW   = $clog2(ROWS);
  localparam logic signed [41:0] SAT_MAX = 42'sd549755813887;
  localparam logic signed [41:0] SAT_MIN = -42'sd549755813888;
  localparam logic signed [49:0] ASAT_MAX = 50'sd549755813887;
  localparam logic signed [49:0] ASAT_MIN = -50'sd549755813888;

  // stores
  logic signed [31:0] mem_x [ROWS];
  logic signed [31:0] mem_y [ROWS];
  logic signed [31:0] mem_z [ROWS];
  logic [41:0]        mem_p [MAX_POINTS];

  logic [13:0]        v_q [3];
  logic [13:0]        p_q [3];
  logic signed [31:0] w_q [3];
  logic signed [46:0] aterm_q [3];
  logic signed [49:0] aacc_q [3];
  logic signed [39:0] acc_q [3];
  logic               ov_q;
  logic [27:0]        sq_q [3];
  logic [29:0]        s_q;
  logic [4:0]         e_q;
  logic [29:0]        norm_q;
  logic [15:0]        mant_q;
  logic signed [21:0] ebias_q;
  logic               kneg_q;
  logic [20:0]        lm_q;
  logic [42:0]        kmag_q;
  logic [50:0]        hi_q [3];
  logic [39:0]        lo_q [3];
  logic               neg_q [3];

  logic [RW-1:0]      wr_addr;
  logic [RW-1:0]      rd_addr;
  logic [13:0]        psel;
  logic signed [46:0] aterm_d [3];
  logic [27:0]        sq_d [3];
  logic [4:0]         e_d;
  logic [3:0]         tidx;
  logic [11:0]        tfr;
  logic [15:0]        tlo;
  logic [15:0]        thi;
  logic [23:0]        tprod;
  logic signed [22:0] ln_d;
  logic [50:0]        kprod;
  logic [31:0]        wm [3];
  logic [55:0]        lprod [3];
  logic [59:0]        mag [3];
  logic [40:0]        magc [3];
  logic signed [41:0] term [3];
  logic signed [41:0] ksum [3];
  logic signed [46:0] aprod [3];
  logic signed [49:0] asum [3];
  logic               ld_ok;
  logic               aov;
  logic               kov;

  assign wr_addr = RW'(index_i);
  assign ld_ok   = (32'(index_i) < ROWS);
  assign rd_addr = (cmd_i.op == OP_ARD) ? RW'(cmd_i.row) : RW'(pt_i) + RW'(AFFINE_ROWS);

  // coefficient store write and read
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LDCOEF && ld_ok) begin
      mem_x[wr_addr] <= coef_x_i;
      mem_y[wr_addr] <= coef_y_i;
      mem_z[wr_addr] <= coef_z_i;
    end
    if (cmd_i.op == OP_ARD || cmd_i.op == OP_PRD) begin
      w_q[0] <= mem_x[rd_addr];
      w_q[1] <= mem_y[rd_addr];
      w_q[2] <= mem_z[rd_addr];
    end
  end

  // control point store write and read
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LDPT && 32'(index_i) < MAX_POINTS) begin
      mem_p[PIW'(index_i)] <= {pos_z_i & POS_MASK, pos_y_i & POS_MASK, pos_x_i & POS_MASK};
    end
    if (cmd_i.op == OP_PRD) begin
      p_q[0] <= mem_p[pt_i][13:0];
      p_q[1] <= mem_p[pt_i][27:14];
      p_q[2] <= mem_p[pt_i][41:28];
    end
  end

  // affine lanes: product shifted toward zero, or the constant row
  always_comb begin
    case (cmd_i.row)
      2'd1:    psel = v_q[0];
      2'd2:    psel = v_q[1];
      default: psel = v_q[2];
    endcase
    for (int a = 0; a < 3; a++) begin
      aprod[a] = $signed({1'b0, psel}) * w_q[a];
      if (cmd_i.row == 2'd0) begin
        aterm_d[a] = 47'(w_q[a]);
      end else if (aprod[a] < 0) begin
        aterm_d[a] = (aprod[a] + 47'sd15) >>> 4;
      end else begin
        aterm_d[a] = aprod[a] >>> 4;
      end
      asum[a] = aacc_q[a] + 50'(aterm_q[a]);
    end
  end

  // squared differences and leading one of the squared distance
  always_comb begin
    logic signed [14:0] d;
    logic signed [29:0] dd;
    for (int a = 0; a < 3; a++) begin
      d        = $signed({1'b0, v_q[a]}) - $signed({1'b0, p_q[a]});
      dd       = d * d;
      sq_d[a]  = dd[27:0];
    end
    e_d = '0;
    for (int j = 0; j < 30; j++) begin
      if (s_q[j]) begin
        e_d = 5'(j);
      end
    end
  end

  // log table interpolation and kernel product
  always_comb begin
    tidx  = norm_q[28:25];
    tfr   = norm_q[24:13];
    tlo   = ln_tab({1'b0, tidx});
    thi   = ln_tab(5'({1'b0, tidx}) + 5'd1);
    tprod = (thi - tlo) * 24'(tfr);
    ln_d  = 23'(ebias_q) + $signed({7'd0, mant_q});
    kprod = 51'(s_q) * 51'(lm_q);
  end

  // kernel term lanes
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      wm[a]    = w_q[a][31] ? 32'(-w_q[a]) : 32'(w_q[a]);
      lprod[a] = 56'(kmag_q[23:0]) * 56'(wm[a]);
      mag[a]   = {1'b0, hi_q[a], 8'd0} + 60'(lo_q[a]);
      magc[a]  = (mag[a] > 60'h100_0000_0000) ? 41'h100_0000_0000 : mag[a][40:0];
      term[a]  = neg_q[a] ? -$signed({1'b0, magc[a]}) : $signed({1'b0, magc[a]});
      ksum[a]  = 42'(acc_q[a]) + term[a];
    end
  end

  // saturation flags of the affine sums and of the kernel sums
  always_comb begin
    aov = 1'b0;
    kov = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (aacc_q[a] > ASAT_MAX || aacc_q[a] < ASAT_MIN) begin
        aov = 1'b1;
      end
      if (ksum[a] > SAT_MAX || ksum[a] < SAT_MIN) begin
        kov = 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_START: ov_q <= 1'b0;
        OP_ASAT: begin
          if (aov) begin
            ov_q <= 1'b1;
          end
        end
        OP_ADD: begin
          if (s_q != '0 && kov) begin
            ov_q <= 1'b1;
          end
        end
        default: ov_q <= ov_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        v_q[0] <= pos_x_i & POS_MASK;
        v_q[1] <= pos_y_i & POS_MASK;
        v_q[2] <= pos_z_i & POS_MASK;
        for (int a = 0; a < 3; a++) aacc_q[a] <= '0;
      end
      OP_AMUL: begin
        for (int a = 0; a < 3; a++) aterm_q[a] <= aterm_d[a];
      end
      OP_AACC: begin
        for (int a = 0; a < 3; a++) aacc_q[a] <= asum[a];
      end
      OP_ASAT: begin
        for (int a = 0; a < 3; a++) begin
          if (aacc_q[a] > ASAT_MAX) begin
            acc_q[a] <= SAT_MAX[39:0];
          end else if (aacc_q[a] < ASAT_MIN) begin
            acc_q[a] <= SAT_MIN[39:0];
          end else begin
            acc_q[a] <= aacc_q[a][39:0];
          end
        end
      end
      OP_DIST: begin
        for (int a = 0; a < 3; a++) sq_q[a] <= sq_d[a];
      end
      OP_SUM: s_q <= 30'(sq_q[0]) + 30'(sq_q[1]) + 30'(sq_q[2]);
      OP_LZ: begin
        e_q    <= e_d;
        norm_q <= s_q << (5'd29 - e_d);
      end
      OP_LN1: begin
        mant_q  <= tlo + 16'(tprod >> 12);
        ebias_q <= 22'($signed({1'b0, e_q}) - 6'sd8) * 22'sd45426;
      end
      OP_LN2: begin
        kneg_q <= ln_d < 0;
        lm_q   <= (ln_d < 0) ? 21'(-ln_d) : 21'(ln_d);
      end
      OP_KM: kmag_q <= kprod[50:8];
      OP_T1: begin
        for (int a = 0; a < 3; a++) begin
          hi_q[a]  <= 51'(kmag_q[42:24]) * 51'(wm[a]);
          neg_q[a] <= kneg_q ^ w_q[a][31];
        end
      end
      OP_T2: begin
        for (int a = 0; a < 3; a++) lo_q[a] <= lprod[a][55:16];
      end
      OP_ADD: begin
        if (s_q != '0) begin
          for (int a = 0; a < 3; a++) begin
            if (ksum[a] > SAT_MAX) begin
              acc_q[a] <= SAT_MAX[39:0];
            end else if (ksum[a] < SAT_MIN) begin
              acc_q[a] <= SAT_MIN[39:0];
            end else begin
              acc_q[a] <= ksum[a][39:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign mapped_x_o = acc_q[0];
  assign mapped_y_o = acc_q[1];
  assign mapped_z_o = acc_q[2];
  assign overflow_o = ov_q;

endmodule
`default_nettype wire
